@@ rtl/core/bfpf_pkg.sv @@
// Shared types and constants for the binary frame parser with Fletcher-8 check.
`timescale 1ns / 1ps
`default_nettype none
package bfpf_pkg;

  // Parser phase codes, also reported on the result channel
  localparam logic [3:0] PH_IDLE    = 4'd0;
  localparam logic [3:0] PH_SYNC1   = 4'd1;
  localparam logic [3:0] PH_SYNC2   = 4'd2;
  localparam logic [3:0] PH_CLASS   = 4'd3;
  localparam logic [3:0] PH_ID      = 4'd4;
  localparam logic [3:0] PH_LENLO   = 4'd5;
  localparam logic [3:0] PH_PAYLOAD = 4'd6;
  localparam logic [3:0] PH_CHKA    = 4'd7;
  localparam logic [3:0] PH_CHKB    = 4'd8;
  localparam logic [3:0] PH_DONE    = 4'd9;

  // Configuration register indexes
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LENGTH_LIMIT = 2'd2;

  localparam logic [7:0]  SYNC_FIRST_RST   = 8'd181;
  localparam logic [7:0]  SYNC_SECOND_RST  = 8'd98;
  localparam logic [15:0] LENGTH_LIMIT_RST = 16'd256;

  // Field read
  localparam int         OFF_W    = 8;
  localparam int         FIELD_W  = 32;
  localparam int         LANES    = 4;
  localparam logic [2:0] MAX_SIZE = 3'd4;

  // Payload store write from the parser
  typedef struct packed {
    logic       en;
    logic [7:0] data;
  } bfpf_wr_t;

  // Parser view reported with an item
  typedef struct packed {
    logic [3:0]  phase;
    logic        done;
    logic [7:0]  frame_class;
    logic [7:0]  frame_id;
    logic [15:0] frame_length;
  } bfpf_rpt_t;

endpackage
`default_nettype wire

@@ rtl/core/bfpf_parser.sv @@
// Frame parser state machine with running Fletcher-8 sums and store write control.
`timescale 1ns / 1ps
`default_nettype none
module bfpf_parser #(
  parameter int PAYLOAD_DEPTH = 256
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                feed,
  input  wire logic [7:0]                          rx_byte,
  input  wire logic [7:0]                          sync_first,
  input  wire logic [7:0]                          sync_second,
  input  wire logic [15:0]                         length_limit,
  output bfpf_pkg::bfpf_wr_t                       wr,
  output logic [$clog2(PAYLOAD_DEPTH)-1:0]         wr_addr,
  output bfpf_pkg::bfpf_rpt_t                      rpt
);
  import bfpf_pkg::*;

  localparam int IDX_W = $clog2(PAYLOAD_DEPTH);
  localparam int CNT_W = $clog2(PAYLOAD_DEPTH + 1);

  logic [3:0]       phase_r, phase_nxt;
  logic [7:0]       sum_a_r, sum_a_nxt;
  logic [7:0]       sum_b_r, sum_b_nxt;
  logic [7:0]       class_r, class_nxt;
  logic [7:0]       id_r, id_nxt;
  logic [15:0]      len_r, len_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic [7:0]       fold_a, fold_b;
  logic [15:0]      len_full;
  logic [CNT_W-1:0] cnt_inc;
  logic             done;

  assign fold_a   = sum_a_r + rx_byte;
  assign fold_b   = sum_b_r + fold_a;
  assign len_full = {rx_byte, len_r[7:0]};
  assign cnt_inc  = cnt_r + CNT_W'(1);
  assign wr_addr  = cnt_r[IDX_W-1:0];

  always_comb begin
    phase_nxt = phase_r;
    sum_a_nxt = sum_a_r;
    sum_b_nxt = sum_b_r;
    class_nxt = class_r;
    id_nxt    = id_r;
    len_nxt   = len_r;
    cnt_nxt   = cnt_r;
    done      = 1'b0;
    wr.en     = 1'b0;
    wr.data   = rx_byte;
    unique case (phase_r)
      PH_IDLE: begin
        if (rx_byte == sync_first) phase_nxt = PH_SYNC1;
      end
      PH_SYNC1: begin
        if (rx_byte == sync_second) begin
          phase_nxt = PH_SYNC2;
          sum_a_nxt = 8'h00;
          sum_b_nxt = 8'h00;
        end else begin
          phase_nxt = PH_IDLE;
        end
      end
      PH_SYNC2: begin
        class_nxt = rx_byte;
        sum_a_nxt = fold_a;
        sum_b_nxt = fold_b;
        phase_nxt = PH_CLASS;
      end
      PH_CLASS: begin
        id_nxt    = rx_byte;
        sum_a_nxt = fold_a;
        sum_b_nxt = fold_b;
        phase_nxt = PH_ID;
      end
      PH_ID: begin
        len_nxt   = {8'h00, rx_byte};
        sum_a_nxt = fold_a;
        sum_b_nxt = fold_b;
        phase_nxt = PH_LENLO;
      end
      PH_LENLO: begin
        len_nxt = len_full;
        if (len_full < length_limit) begin
          sum_a_nxt = fold_a;
          sum_b_nxt = fold_b;
          cnt_nxt   = '0;
          phase_nxt = (len_full != 16'd0) ? PH_PAYLOAD : PH_CHKA;
        end else begin
          phase_nxt = PH_IDLE;
        end
      end
      PH_PAYLOAD: begin
        if (cnt_r < CNT_W'(PAYLOAD_DEPTH)) begin
          sum_a_nxt = fold_a;
          sum_b_nxt = fold_b;
          wr.en     = 1'b1;
          cnt_nxt   = cnt_inc;
          if (16'(cnt_inc) == len_r) phase_nxt = PH_CHKA;
        end else begin
          // store full: byte dropped, frame aborted
          phase_nxt = PH_IDLE;
        end
      end
      PH_CHKA: begin
        phase_nxt = (rx_byte == sum_a_r) ? PH_CHKB : PH_IDLE;
      end
      PH_CHKB: begin
        phase_nxt = PH_IDLE;
        done      = (rx_byte == sum_b_r);
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
    wr.en = wr.en & feed;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      sum_a_r <= 8'h00;
      sum_b_r <= 8'h00;
      class_r <= 8'h00;
      id_r    <= 8'h00;
      len_r   <= 16'h0000;
      cnt_r   <= '0;
    end else if (feed) begin
      phase_r <= phase_nxt;
      sum_a_r <= sum_a_nxt;
      sum_b_r <= sum_b_nxt;
      class_r <= class_nxt;
      id_r    <= id_nxt;
      len_r   <= len_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // State as it stands after this item
  always_comb begin
    if (feed) begin
      rpt.phase        = done ? PH_DONE : phase_nxt;
      rpt.done         = done;
      rpt.frame_class  = class_nxt;
      rpt.frame_id     = id_nxt;
      rpt.frame_length = len_nxt;
    end else begin
      rpt.phase        = phase_r;
      rpt.done         = 1'b0;
      rpt.frame_class  = class_r;
      rpt.frame_id     = id_r;
      rpt.frame_length = len_r;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/binary_frame_parser_fletcher_core.sv @@
// Top level of the binary frame parser: handshakes, payload store and field read.
`timescale 1ns / 1ps
`default_nettype none
// Byte-serial frame parser (sync, sync, class, id, 16-bit LE length, payload,
// Fletcher-8 A/B) with a payload store that can be read back as 1, 2, 3 or 4
// byte little-endian fields. One item per cycle sustained while the result is
// not stalled; each item passes through the input stage, then the result
// register. The parser updates its state in the cycle an item is taken, so
// it never holds back the item rate. The payload store is split into four byte
// banks by the low two offset bits, each with one write and one read port,
// so a 4-byte field read costs one store access. Store data is registered in
// the first stage and the field is assembled into the result register.
// No clearing pass after reset: unwritten store entries are undefined.
// cfg_ready is always high; write registers only while the block is idle.
// in_stall rises only when the first stage is full and the result is stalled.
module binary_frame_parser_fletcher_core #(
  parameter int PAYLOAD_DEPTH = 256
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // item input
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic                               in_opcode,
  input  wire logic [7:0]                         in_rx_byte,
  input  wire logic [bfpf_pkg::OFF_W-1:0]         in_read_offset,
  input  wire logic [2:0]                         in_read_size,
  input  wire logic                               in_read_signed,
  // result output
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic [3:0]                              out_phase,
  output logic                                    out_frame_done,
  output logic [7:0]                              out_frame_class,
  output logic [7:0]                              out_frame_id,
  output logic [15:0]                             out_frame_length,
  output logic [bfpf_pkg::FIELD_W-1:0]            out_field_value,
  // register writes
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [bfpf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [bfpf_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import bfpf_pkg::*;

  localparam int IDX_W  = $clog2(PAYLOAD_DEPTH);
  localparam int BANK_D = (PAYLOAD_DEPTH + LANES - 1) / LANES;
  localparam int ROW_W  = $clog2(BANK_D);
  // wide enough for offset plus three and for any store index
  localparam int AW     = (IDX_W > OFF_W + 1) ? IDX_W : OFF_W + 1;

  // ---------------- configuration ----------------
  logic [7:0]  sync_first_r;
  logic [7:0]  sync_second_r;
  logic [15:0] length_limit_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_first_r   <= SYNC_FIRST_RST;
      sync_second_r  <= SYNC_SECOND_RST;
      length_limit_r <= LENGTH_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SYNC_FIRST:   sync_first_r   <= cfg_data[7:0];
        CFG_SYNC_SECOND:  sync_second_r  <= cfg_data[7:0];
        CFG_LENGTH_LIMIT: length_limit_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------- flow control ----------------
  logic s1_valid_r;
  logic out_valid_r;
  logic adv;
  logic in_acc;

  // result register free, or being taken this cycle
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !adv;
  assign in_acc   = in_valid && !in_stall;

  // ---------------- parser ----------------
  bfpf_wr_t           wr;
  logic [IDX_W-1:0]   wr_addr;
  bfpf_rpt_t          rpt;

  bfpf_parser #(
    .PAYLOAD_DEPTH(PAYLOAD_DEPTH)
  ) u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .feed         (in_acc && !in_opcode),
    .rx_byte      (in_rx_byte),
    .sync_first   (sync_first_r),
    .sync_second  (sync_second_r),
    .length_limit (length_limit_r),
    .wr           (wr),
    .wr_addr      (wr_addr),
    .rpt          (rpt)
  );

  // ---------------- payload store, four byte banks ----------------
  logic       rd_go;
  logic [7:0] s1_rd_r [LANES];

  assign rd_go = in_acc && in_opcode;

  for (genvar j = 0; j < LANES; j++) begin : g_bank
    logic [7:0]    mem [BANK_D];
    logic [1:0]    lane;
    logic [AW-1:0] idx;
    logic          inr;

    // which byte of the field lands in this bank
    assign lane = 2'(j) - in_read_offset[1:0];
    assign idx  = AW'(in_read_offset) + AW'(lane);
    assign inr  = (32'(idx) < PAYLOAD_DEPTH);

    always_ff @(posedge clk) begin
      if (wr.en && (wr_addr[1:0] == 2'(j))) begin
        mem[wr_addr[ROW_W+1:2]] <= wr.data;
      end
      if (rd_go && inr) begin
        s1_rd_r[j] <= mem[idx[ROW_W+1:2]];
      end
    end
  end

  // ---------------- first stage ----------------
  bfpf_rpt_t        s1_rpt_r;
  logic [1:0]       s1_rot_r;
  logic [2:0]       s1_n_r;
  logic             s1_sgn_r;
  logic [LANES-1:0] s1_lane_ok_r;

  logic [2:0]       n_clamp;
  logic [LANES-1:0] lane_ok;

  assign n_clamp = (in_read_size > MAX_SIZE) ? MAX_SIZE : in_read_size;

  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      lane_ok[k] = in_opcode && (3'(k) < n_clamp)
                   && (32'(AW'(in_read_offset) + AW'(k)) < PAYLOAD_DEPTH);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_rpt_r     <= rpt;
      s1_rot_r     <= in_read_offset[1:0];
      s1_n_r       <= n_clamp;
      s1_sgn_r     <= in_read_signed;
      s1_lane_ok_r <= lane_ok;
    end
  end

  // ---------------- field assembly ----------------
  logic [FIELD_W-1:0] field;

  always_comb begin
    field = '0;
    for (int k = 0; k < LANES; k++) begin
      if (s1_lane_ok_r[k]) field[8*k +: 8] = s1_rd_r[2'(s1_rot_r + 2'(k))];
    end
    unique case (s1_n_r)
      3'd1:    if (s1_sgn_r && field[7])  field[FIELD_W-1:8]  = '1;
      3'd2:    if (s1_sgn_r && field[15]) field[FIELD_W-1:16] = '1;
      3'd3:    if (s1_sgn_r && field[23]) field[FIELD_W-1:24] = '1;
      default: ;
    endcase
  end

  // ---------------- result register ----------------
  bfpf_rpt_t          out_rpt_r;
  logic [FIELD_W-1:0] out_field_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_valid_r) begin
      out_rpt_r   <= s1_rpt_r;
      out_field_r <= field;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_phase        = out_rpt_r.phase;
  assign out_frame_done   = out_rpt_r.done;
  assign out_frame_class  = out_rpt_r.frame_class;
  assign out_frame_id     = out_rpt_r.frame_id;
  assign out_frame_length = out_rpt_r.frame_length;
  assign out_field_value  = out_field_r;

endmodule
`default_nettype wire

@@ rtl/core/bfpf_checker.sv @@
// Port-level checks for the frame parser core, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module bfpf_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_stall,
  input wire logic                        out_valid,
  input wire logic                        out_stall,
  input wire logic [3:0]                  out_phase,
  input wire logic                        out_frame_done,
  input wire logic [bfpf_pkg::FIELD_W-1:0] out_field_value
);
  import bfpf_pkg::*;

  // nothing comes out straight after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_phase)
      && $stable(out_frame_done) && $stable(out_field_value))
    else $error("stalled result changed");

  // done flag and completion phase go together
  a_done_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_frame_done == (out_phase == PH_DONE)))
    else $error("frame_done does not match phase");

  // a completing byte is a feed, so no field value
  a_done_no_field: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_done |-> out_field_value == '0)
    else $error("field value on a completed frame");

  // input backs up only behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output back-pressure");

endmodule

bind binary_frame_parser_fletcher_core bfpf_checker u_bfpf_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_phase       (out_phase),
  .out_frame_done  (out_frame_done),
  .out_field_value (out_field_value)
);
`default_nettype wire

@@ verif/bfpf_frame_checker.sv @@
// Result checker for the frame parser: predicts every result from the accepted items.
`timescale 1ns / 1ps
module bfpf_frame_checker #(
  parameter int   PAYLOAD_DEPTH = 256,
  parameter logic READ_OP       = 1'b1
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic                              in_opcode,
  input  logic [7:0]                        in_rx_byte,
  input  logic [bfpf_pkg::OFF_W-1:0]        in_read_offset,
  input  logic [2:0]                        in_read_size,
  input  logic                              in_read_signed,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic [3:0]                        out_phase,
  input  logic                              out_frame_done,
  input  logic [7:0]                        out_frame_class,
  input  logic [7:0]                        out_frame_id,
  input  logic [15:0]                       out_frame_length,
  input  logic [bfpf_pkg::FIELD_W-1:0]      out_field_value,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [bfpf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bfpf_pkg::CFG_DATA_W-1:0]   cfg_data,
  output int                                fail_count,
  output int                                results_owed,
  output logic [PAYLOAD_DEPTH-1:0]          bytes_written
);
  import bfpf_pkg::*;

  typedef struct packed {
    bfpf_rpt_t          rpt;
    logic [FIELD_W-1:0] field;
  } parse_result_t;

  parse_result_t results_due[$];

  logic [7:0]               cur_sync_first;
  logic [7:0]               cur_sync_second;
  logic [15:0]              cur_length_limit;

  logic [3:0]               phase_now;
  logic [7:0]               run_a;
  logic [7:0]               run_b;
  logic [7:0]               last_class;
  logic [7:0]               last_id;
  logic [15:0]              last_length;
  int unsigned              stored_count;
  logic [7:0]               store_copy [PAYLOAD_DEPTH];
  logic [PAYLOAD_DEPTH-1:0] written_now;

  int mismatches = 0;
  int results_seen = 0;

  task automatic report_mismatch(input string what, input logic [31:0] got_v,
                                 input logic [31:0] want_v);
    mismatches++;
    $display("[%0t] result %0d: %s got 0x%0h, want 0x%0h",
             $time, results_seen, what, got_v, want_v);
  endtask

  function automatic void fold_in(input logic [7:0] b);
    run_a = run_a + b;
    run_b = run_b + run_a;
  endfunction

  // one received byte through the parser; returns the phase shown with it
  function automatic logic [3:0] take_byte(input logic [7:0] b);
    logic good_frame;
    good_frame = 1'b0;
    case (phase_now)
      PH_IDLE: begin
        if (b == cur_sync_first) phase_now = PH_SYNC1;
      end
      PH_SYNC1: begin
        if (b == cur_sync_second) begin
          phase_now = PH_SYNC2;
          run_a = '0;
          run_b = '0;
        end else begin
          phase_now = PH_IDLE;
        end
      end
      PH_SYNC2: begin
        last_class = b;
        fold_in(b);
        phase_now = PH_CLASS;
      end
      PH_CLASS: begin
        last_id = b;
        fold_in(b);
        phase_now = PH_ID;
      end
      PH_ID: begin
        last_length = {8'h00, b};
        fold_in(b);
        phase_now = PH_LENLO;
      end
      PH_LENLO: begin
        last_length = {b, last_length[7:0]};
        if (last_length < cur_length_limit) begin
          fold_in(b);
          stored_count = 0;
          phase_now = (last_length != 16'd0) ? PH_PAYLOAD : PH_CHKA;
        end else begin
          phase_now = PH_IDLE;
        end
      end
      PH_PAYLOAD: begin
        if (stored_count < PAYLOAD_DEPTH) begin
          fold_in(b);
          store_copy[stored_count] = b;
          written_now[stored_count] = 1'b1;
          stored_count++;
          if (stored_count == last_length) phase_now = PH_CHKA;
        end else begin
          phase_now = PH_IDLE;
        end
      end
      PH_CHKA: begin
        phase_now = (b == run_a) ? PH_CHKB : PH_IDLE;
      end
      PH_CHKB: begin
        phase_now = PH_IDLE;
        good_frame = (b == run_b);
      end
      default: begin
        phase_now = PH_IDLE;
      end
    endcase
    return good_frame ? PH_DONE : phase_now;
  endfunction

  // little-endian field from the payload copy; bytes past the store are zero
  function automatic logic [FIELD_W-1:0] pick_field(input logic [7:0] off,
                                                    input logic [2:0] size,
                                                    input logic sgn);
    int unsigned n;
    int unsigned idx;
    logic [FIELD_W-1:0] v;
    n = (size > MAX_SIZE) ? MAX_SIZE : size;
    v = '0;
    for (int k = 0; k < n; k++) begin
      idx = off + k;
      if (idx < PAYLOAD_DEPTH) v[8*k +: 8] = store_copy[idx];
    end
    if (sgn && n >= 1 && n <= 3 && v[8*n-1]) v = v | ({FIELD_W{1'b1}} << (8*n));
    return v;
  endfunction

  always @(posedge clk) begin
    parse_result_t got_res;
    parse_result_t want_res;
    if (!rst_n) begin
      cur_sync_first   = SYNC_FIRST_RST;
      cur_sync_second  = SYNC_SECOND_RST;
      cur_length_limit = LENGTH_LIMIT_RST;
      phase_now        = PH_IDLE;
      run_a            = '0;
      run_b            = '0;
      last_class       = '0;
      last_id          = '0;
      last_length      = '0;
      stored_count     = 0;
      written_now      = '0;
      for (int i = 0; i < PAYLOAD_DEPTH; i++) store_copy[i] = '0;
      results_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SYNC_FIRST:   cur_sync_first   = cfg_data[7:0];
          CFG_SYNC_SECOND:  cur_sync_second  = cfg_data[7:0];
          CFG_LENGTH_LIMIT: cur_length_limit = cfg_data[15:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        results_seen++;
        got_res = {out_phase, out_frame_done, out_frame_class, out_frame_id,
                   out_frame_length, out_field_value};
        if (results_due.size() == 0) begin
          report_mismatch("result with nothing outstanding, phase", got_res.rpt.phase, '0);
        end else begin
          want_res = results_due.pop_front();
          if (got_res.rpt.phase !== want_res.rpt.phase)
            report_mismatch("phase", got_res.rpt.phase, want_res.rpt.phase);
          if (got_res.rpt.done !== want_res.rpt.done)
            report_mismatch("frame_done", got_res.rpt.done, want_res.rpt.done);
          if (got_res.rpt.frame_class !== want_res.rpt.frame_class)
            report_mismatch("frame_class", got_res.rpt.frame_class, want_res.rpt.frame_class);
          if (got_res.rpt.frame_id !== want_res.rpt.frame_id)
            report_mismatch("frame_id", got_res.rpt.frame_id, want_res.rpt.frame_id);
          if (got_res.rpt.frame_length !== want_res.rpt.frame_length)
            report_mismatch("frame_length", got_res.rpt.frame_length,
                            want_res.rpt.frame_length);
          if (got_res.field !== want_res.field)
            report_mismatch("field_value", got_res.field, want_res.field);
        end
      end
      if (in_valid && !in_stall) begin
        want_res.field = '0;
        if (in_opcode == READ_OP) begin
          // a read leaves the parser alone
          want_res.rpt.phase = phase_now;
          want_res.field = pick_field(in_read_offset, in_read_size, in_read_signed);
        end else begin
          want_res.rpt.phase = take_byte(in_rx_byte);
        end
        want_res.rpt.done         = (want_res.rpt.phase == PH_DONE);
        want_res.rpt.frame_class  = last_class;
        want_res.rpt.frame_id     = last_id;
        want_res.rpt.frame_length = last_length;
        results_due.push_back(want_res);
      end
    end
    fail_count    <= mismatches;
    results_owed  <= results_due.size();
    bytes_written <= written_now;
  end

endmodule

@@ verif/testbench.sv @@
// Testbench top for the frame parser: clock, reset, item stimulus, stalls and verdict.
`timescale 1ns / 1ps
module testbench;
  import bfpf_pkg::*;

  localparam int PAYLOAD_DEPTH = 256;
  // limit on the run length; leaves ample margin over the slowest legal run
  localparam int CYCLE_LIMIT   = 400000;

  // item opcodes
  localparam logic OP_FEED = 1'b0;
  localparam logic OP_READ = 1'b1;

  // ways of spoiling an otherwise well-formed frame
  typedef enum int {
    DMG_NONE,
    DMG_SYNC,
    DMG_LENGTH,
    DMG_SUM_A,
    DMG_SUM_B
  } frame_damage_t;

  logic                   clk;
  logic                   rst_n;

  logic                   in_valid;
  logic                   in_stall;
  logic                   in_opcode;
  logic [7:0]             in_rx_byte;
  logic [OFF_W-1:0]       in_read_offset;
  logic [2:0]             in_read_size;
  logic                   in_read_signed;

  logic                   out_valid;
  logic                   out_stall;
  logic [3:0]             out_phase;
  logic                   out_frame_done;
  logic [7:0]             out_frame_class;
  logic [7:0]             out_frame_id;
  logic [15:0]            out_frame_length;
  logic [FIELD_W-1:0]     out_field_value;

  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  int                       fail_count;
  int                       results_owed;
  logic [PAYLOAD_DEPTH-1:0] bytes_written;

  // register settings as last written, needed to build frames
  logic [7:0]  sync_first_now;
  logic [7:0]  sync_second_now;
  logic [15:0] length_limit_now;

  bit quiet        = 1'b0;  // no idling on either side while set
  int squeeze_req  = 0;     // long receiver hold-offs asked for
  int squeeze_done = 0;     // ... and carried out
  int items_sent   = 0;
  int cycle_count  = 0;

  binary_frame_parser_fletcher_core #(
    .PAYLOAD_DEPTH(PAYLOAD_DEPTH)
  ) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_opcode        (in_opcode),
    .in_rx_byte       (in_rx_byte),
    .in_read_offset   (in_read_offset),
    .in_read_size     (in_read_size),
    .in_read_signed   (in_read_signed),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_phase        (out_phase),
    .out_frame_done   (out_frame_done),
    .out_frame_class  (out_frame_class),
    .out_frame_id     (out_frame_id),
    .out_frame_length (out_frame_length),
    .out_field_value  (out_field_value),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  bfpf_frame_checker #(
    .PAYLOAD_DEPTH (PAYLOAD_DEPTH),
    .READ_OP       (OP_READ)
  ) u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_opcode        (in_opcode),
    .in_rx_byte       (in_rx_byte),
    .in_read_offset   (in_read_offset),
    .in_read_size     (in_read_size),
    .in_read_signed   (in_read_signed),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_phase        (out_phase),
    .out_frame_done   (out_frame_done),
    .out_frame_class  (out_frame_class),
    .out_frame_id     (out_frame_id),
    .out_frame_length (out_frame_length),
    .out_field_value  (out_field_value),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .fail_count       (fail_count),
    .results_owed     (results_owed),
    .bytes_written    (bytes_written)
  );

  // 4 ns clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Idle gap length: mostly none, often short, now and then long.
  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offer one item and wait for it to be taken. Valid stays high straight
  // into the next item when there is no gap, so only one update per edge.
  task automatic drive_item(input logic op, input logic [7:0] b, input logic [7:0] off,
                            input logic [2:0] size, input logic sgn);
    int gap;
    gap = quiet ? 0 : idle_length();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_opcode      <= op;
    in_rx_byte     <= b;
    in_read_offset <= off;
    in_read_size   <= size;
    in_read_signed <= sgn;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  // Received byte; the read fields are don't-care, so keep them moving.
  task automatic feed_byte(input logic [7:0] b);
    drive_item(OP_FEED, b, 8'($urandom), 3'($urandom), 1'($urandom));
  endtask

  // A read may only touch store entries that some payload byte has filled.
  // The written map comes registered from the checker, which only errs safe.
  function automatic bit readable(input logic [7:0] off, input logic [2:0] size);
    int n;
    n = (size > MAX_SIZE) ? MAX_SIZE : size;
    for (int k = 0; k < n; k++)
      if (off + k < PAYLOAD_DEPTH && !bytes_written[off + k]) return 1'b0;
    return 1'b1;
  endfunction

  task automatic read_random();
    logic [7:0] off;
    logic [2:0] size;
    for (int tries = 0; tries < 24; tries++) begin
      off  = 8'(($urandom_range(0, 1) != 0) ? $urandom_range(0, 15)
                                            : $urandom_range(0, 255));
      size = 3'($urandom_range(0, 7));
      if (readable(off, size)) break;
    end
    // size zero reads nothing, so it is always allowed
    if (!readable(off, size)) size = '0;
    drive_item(OP_READ, 8'($urandom), off, size, 1'($urandom));
  endtask

  // Frame byte after the first sync; reads slip in now and then since they
  // leave the parser untouched.
  task automatic frame_byte(input logic [7:0] b);
    if ($urandom_range(0, 99) < 8) read_random();
    feed_byte(b);
  endtask

  function automatic logic [7:0] any_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'h7F;
      2:       return 8'h80;
      3:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // Valid lengths: mostly short, a few up to 255.
  function automatic logic [15:0] pick_length();
    int cap;
    int r;
    cap = int'(length_limit_now) - 1;
    if (cap > 255) cap = 255;
    r = $urandom_range(0, 99);
    if (r < 55) return 16'($urandom_range(0, (cap < 8) ? cap : 8));
    if (r < 90) return 16'($urandom_range(0, (cap < 24) ? cap : 24));
    return 16'($urandom_range(0, cap));
  endfunction

  // A length the parser must refuse: at the limit, just over, or the maximum.
  function automatic logic [15:0] over_length();
    int len;
    len = int'(length_limit_now) + $urandom_range(0, 3);
    if ($urandom_range(0, 3) == 0 || len > 16'hFFFF) len = 16'hFFFF;
    return 16'(len);
  endfunction

  // Whole frame with its Fletcher pair worked out here, optionally spoilt.
  task automatic send_frame(input logic [15:0] len, input frame_damage_t dmg);
    logic [7:0] hdr [4];
    logic [7:0] sa;
    logic [7:0] sb;
    logic [7:0] b;
    sa = '0;
    sb = '0;
    feed_byte(sync_first_now);
    if (dmg == DMG_SYNC) begin
      // anything but the second sync drops the parser back to idle
      frame_byte(sync_second_now ^ 8'($urandom_range(1, 255)));
      return;
    end
    frame_byte(sync_second_now);
    hdr[0] = any_byte();
    hdr[1] = any_byte();
    hdr[2] = len[7:0];
    hdr[3] = len[15:8];
    for (int i = 0; i < 4; i++) begin
      frame_byte(hdr[i]);
      sa = sa + hdr[i];
      sb = sb + sa;
    end
    if (len >= length_limit_now) return;
    // past the store depth the parser aborts and the rest is just noise
    for (int i = 0; i < len; i++) begin
      b = any_byte();
      frame_byte(b);
      sa = sa + b;
      sb = sb + sa;
    end
    frame_byte((dmg == DMG_SUM_A) ? (sa ^ 8'($urandom_range(1, 255))) : sa);
    frame_byte((dmg == DMG_SUM_B) ? (sb ^ 8'($urandom_range(1, 255))) : sb);
  endtask

  // Mostly good frames with random content; the rest broken frames,
  // stray bytes and field reads.
  task automatic run_traffic(input int budget);
    int stop_at;
    int r;
    stop_at = items_sent + budget;
    while (items_sent < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 62) begin
        send_frame(pick_length(), DMG_NONE);
      end else if (r < 68) begin
        send_frame(pick_length(), DMG_SYNC);
      end else if (r < 72) begin
        send_frame(pick_length(), DMG_SUM_A);
      end else if (r < 76) begin
        send_frame(pick_length(), DMG_SUM_B);
      end else if (r < 80) begin
        send_frame(over_length(), DMG_LENGTH);
      end else if (r < 88) begin
        feed_byte(($urandom_range(0, 4) == 0) ? sync_first_now : any_byte());
      end else begin
        read_random();
      end
    end
  endtask

  // Stop offering and wait until every result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
  endtask

  // All three registers back to back; only called with the block empty.
  // Sync registers take the low byte, so the high byte carries junk.
  task automatic program_regs(input logic [7:0] sf, input logic [7:0] ss,
                              input logic [15:0] lim);
    logic [CFG_IDX_W-1:0]  reg_sel [3];
    logic [CFG_DATA_W-1:0] reg_val [3];
    logic [7:0]            junk_a;
    logic [7:0]            junk_b;
    junk_a  = 8'($urandom);
    junk_b  = 8'($urandom);
    reg_sel = '{CFG_SYNC_FIRST, CFG_SYNC_SECOND, CFG_LENGTH_LIMIT};
    reg_val = '{{junk_a, sf}, {junk_b, ss}, lim};
    for (int i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= reg_sel[i];
      cfg_data  <= reg_val[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid        <= 1'b0;
    sync_first_now   = sf;
    sync_second_now  = ss;
    length_limit_now = lim;
  endtask

  // Receiver: random stall pattern, plus one long hold-off on request so
  // the block backs up and stalls its input while the sender keeps offering.
  initial begin
    int   len;
    logic hold;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      if (squeeze_done < squeeze_req) begin
        squeeze_done++;
        hold = 1'b1;
        len  = 150;
      end else if (quiet || $urandom_range(0, 2) != 0) begin
        hold = 1'b0;
        len  = $urandom_range(1, 12);
      end else begin
        hold = 1'b1;
        len  = 1 + idle_length();
      end
      out_stall <= hold;
      repeat (len) @(posedge clk);
    end
  end

  // Watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    logic [7:0] same_sync;
    rst_n            <= 1'b0;
    in_valid         <= 1'b0;
    in_opcode        <= OP_FEED;
    in_rx_byte       <= '0;
    in_read_offset   <= '0;
    in_read_size     <= '0;
    in_read_signed   <= 1'b0;
    cfg_valid        <= 1'b0;
    cfg_index        <= CFG_SYNC_FIRST;
    cfg_data         <= '0;
    sync_first_now   = SYNC_FIRST_RST;
    sync_second_now  = SYNC_SECOND_RST;
    length_limit_now = LENGTH_LIMIT_RST;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed part, reset settings ---
    // size zero reads nothing, at both ends of the offset range
    drive_item(OP_READ, 8'h00, 8'h00, 3'd0, 1'b1);
    drive_item(OP_READ, 8'hFF, 8'hFF, 3'd0, 1'b0);
    // first sync twice: the repeat is a wrong second sync and is not taken
    // as a fresh start, so the real second sync then finds the parser idle
    feed_byte(SYNC_FIRST_RST);
    feed_byte(SYNC_FIRST_RST);
    feed_byte(SYNC_SECOND_RST);
    // empty payload goes straight to the checksum bytes
    send_frame(16'd0, DMG_NONE);
    // length equal to the limit is refused
    send_frame(LENGTH_LIMIT_RST, DMG_LENGTH);
    drain();

    // --- reset settings, with the long receiver hold-off early on ---
    squeeze_req++;
    run_traffic(35);
    drain();

    // --- sync extremes, widest limit; one frame longer than the store ---
    program_regs(8'h00, 8'hFF, 16'hFFFF);
    send_frame(16'd260, DMG_NONE);
    run_traffic(10);
    drain();

    // --- swapped extremes, tightest limit: only empty frames pass; no idling ---
    program_regs(8'hFF, 8'h00, 16'd1);
    quiet = 1'b1;
    run_traffic(20);
    quiet = 1'b0;
    drain();

    // --- random syncs, small limit ---
    program_regs(8'($urandom), 8'($urandom), 16'($urandom_range(2, 64)));
    run_traffic(20);
    drain();

    // --- both syncs the same byte, limit back to its reset value ---
    same_sync = 8'($urandom);
    program_regs(same_sync, same_sync, LENGTH_LIMIT_RST);
    run_traffic(20);

    drain();
    repeat (10) @(posedge clk);
    if (fail_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
